[sv/assert_macros.svh]
// assertion helpers for the checker file
// macros expect clk in the using scope, all but NEXT_ALWAYS also rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SKHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define SKHT_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/skht_pkg.sv]
// ---------------------------------------------------------------------------
// skht_pkg
// shared constants for the string key hash table probe core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skht_pkg;

  // default geometry
  localparam int SLOTS_DEF         = 4096;
  localparam int MAX_KEY_CHARS_DEF = 30;

  // hash multiplier
  localparam int HASH_MULT = 873;

  // port widths
  localparam int MODE_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 12;

  // operation codes, the spare code behaves as lookup
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT_REMOVED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd5;

endpackage

`default_nettype wire

[sv/string_key_hash_table_probe_core.sv]
// ---------------------------------------------------------------------------
// string_key_hash_table_probe_core
// open addressing hash table of string keys with linear probing
// ---------------------------------------------------------------------------
// A key is sent one byte per transaction on in_key_char, accepted when start
// is high and busy is low; in_key_last marks the final byte, and in_mode on
// that byte selects lookup, insert/restore or mark removed.
// Each byte goes through a registered multiply-add of the running hash,
// then a restoring modulo-SLOTS reduction in state S_RED.
// On the final byte the table is walked from the home slot: each probed slot
// has its metadata read (S_META_RD, S_META_CHK), and when the stored length
// matches, its key bytes are compared (one key byte memory read per cycle).
// An insert into an empty slot then copies the key byte by byte into memory.
// Exactly one result per final byte appears on out_status/out_slot_index for
// one cycle with out_valid; the receiver cannot stall, so nothing waits.
// After reset the slot metadata memory is swept clear slot by slot with
// busy high; no transaction is taken during the sweep.
// Memory writes complete before busy falls, so probes never overlap writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module string_key_hash_table_probe_core #(
  parameter int SLOTS         = skht_pkg::SLOTS_DEF,
  parameter int MAX_KEY_CHARS = skht_pkg::MAX_KEY_CHARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [skht_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [skht_pkg::CHAR_W-1:0]   in_key_char,
  input  wire logic                          in_key_last,
  output logic                               out_valid,
  output logic [skht_pkg::STATUS_W-1:0]      out_status,
  output logic [skht_pkg::SLOT_W-1:0]        out_slot_index
);

  localparam int SW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW      = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
  localparam int LW      = $clog2(MAX_KEY_CHARS + 2);
  localparam int PW      = SW + 10;
  localparam int RED_PER = 5;
  localparam int KDEPTH  = SLOTS << CW;

  localparam logic [PW-1:0] SLOTS_W   = PW'(SLOTS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_KEY_CHARS);

  typedef struct packed {
    logic          occ;
    logic          rem;
    logic [LW-1:0] len;
  } meta_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RED, S_META_RD, S_META_CHK, S_CMP, S_COPY
  } state_t;

  state_t                         state_r;
  logic [SW-1:0]                  h_r;
  logic [LW-1:0]                  len_r;
  logic [skht_pkg::CHAR_W-1:0]    key_buf_r [MAX_KEY_CHARS];
  logic [skht_pkg::MODE_W-1:0]    mode_r;
  logic                           last_r;
  logic [PW-1:0]                  red_x_r;
  logic                           red_cnt_r;
  logic [SW-1:0]                  slot_r;
  logic [SW-1:0]                  n_r;
  logic [LW-1:0]                  idx_r;
  logic                           out_valid_r;
  logic [skht_pkg::STATUS_W-1:0]  out_status_r;
  logic [skht_pkg::SLOT_W-1:0]    out_slot_r;

  // memories: slot metadata and key bytes
  meta_t                          meta_mem [SLOTS];
  meta_t                          meta_q;
  logic [skht_pkg::CHAR_W-1:0]    kmem [KDEPTH];
  logic [skht_pkg::CHAR_W-1:0]    kmem_q;

  logic                           meta_we;
  meta_t                          meta_wdata;
  logic                           kmem_we;
  logic [LW-1:0]                  rd_idx;
  logic [PW-1:0]                  prod;
  logic [PW-1:0]                  red_x_nxt;
  logic [3:0]                     red_top;
  logic [skht_pkg::CHAR_W-1:0]    buf_byte;
  logic [LW-1:0]                  idx_inc;

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  assign idx_inc  = idx_r + LW'(1);
  assign buf_byte = key_buf_r[idx_r[CW-1:0]];

  // hash multiply-add at accept
  assign prod = PW'(skht_pkg::HASH_MULT) * PW'(h_r) + PW'(in_key_char);

  // five restoring reduction steps per cycle
  always_comb begin
    red_top   = red_cnt_r ? 4'(RED_PER - 1) : 4'(2 * RED_PER - 1);
    red_x_nxt = red_x_r;
    for (int j = 0; j < RED_PER; j++) begin
      if (red_x_nxt >= (SLOTS_W << (red_top - 4'(j)))) begin
        red_x_nxt = red_x_nxt - (SLOTS_W << (red_top - 4'(j)));
      end
    end
  end

  // key byte read index
  always_comb begin
    case (state_r)
      S_CMP:   rd_idx = idx_inc;
      default: rd_idx = '0;
    endcase
  end

  // metadata and key byte write decision
  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = '0;
    kmem_we    = (state_r == S_COPY);
    case (state_r)
      S_CLEAR: begin
        meta_we = 1'b1;
      end
      S_META_CHK: begin
        if (!meta_q.occ && mode_r == skht_pkg::MODE_INSERT) begin
          meta_we    = 1'b1;
          meta_wdata = '{occ: 1'b1, rem: 1'b0, len: len_r};
        end
      end
      S_CMP: begin
        if (kmem_q == buf_byte && idx_inc == len_r) begin
          if (mode_r == skht_pkg::MODE_INSERT) begin
            meta_we    = 1'b1;
            meta_wdata = '{occ: 1'b1, rem: 1'b0, len: meta_q.len};
          end else if (mode_r == skht_pkg::MODE_REMOVE) begin
            meta_we    = 1'b1;
            meta_wdata = '{occ: 1'b1, rem: 1'b1, len: meta_q.len};
          end
        end
      end
      default: ;
    endcase
  end

  // metadata memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[slot_r] <= meta_wdata;
    end
    meta_q <= meta_mem[slot_r];
  end

  // key byte memory
  always_ff @(posedge clk) begin
    if (kmem_we) begin
      kmem[{slot_r, idx_r[CW-1:0]}] <= buf_byte;
    end
    kmem_q <= kmem[{slot_r, rd_idx[CW-1:0]}];
  end

  // control sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      slot_r      <= '0;
      h_r         <= '0;
      len_r       <= '0;
      red_cnt_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          if (slot_r == SLOT_LAST) begin
            slot_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            slot_r <= slot_r + SW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            if (len_r < MAX_LEN) begin
              key_buf_r[len_r[CW-1:0]] <= in_key_char;
            end
            if (len_r <= MAX_LEN) begin
              len_r <= len_r + LW'(1);
            end
            mode_r    <= in_mode;
            last_r    <= in_key_last;
            red_x_r   <= prod;
            red_cnt_r <= 1'b0;
            state_r   <= S_RED;
          end
        end
        S_RED: begin
          red_x_r   <= red_x_nxt;
          red_cnt_r <= 1'b1;
          if (red_cnt_r) begin
            h_r     <= red_x_nxt[SW-1:0];
            state_r <= S_IDLE;
            if (last_r) begin
              if (len_r > MAX_LEN) begin
                out_valid_r  <= 1'b1;
                out_status_r <= skht_pkg::ST_TOO_LONG;
                out_slot_r   <= '0;
                h_r          <= '0;
                len_r        <= '0;
              end else begin
                slot_r  <= red_x_nxt[SW-1:0];
                n_r     <= '0;
                state_r <= S_META_RD;
              end
            end
          end
        end
        S_META_RD: begin
          state_r <= S_META_CHK;
        end
        S_META_CHK: begin
          idx_r <= '0;
          if (!meta_q.occ) begin
            // empty slot ends the walk
            out_valid_r <= 1'b1;
            out_slot_r  <= skht_pkg::SLOT_W'(slot_r);
            if (mode_r == skht_pkg::MODE_INSERT) begin
              out_status_r <= skht_pkg::ST_INSERTED;
              state_r      <= S_COPY;
            end else begin
              out_status_r <= skht_pkg::ST_MISS;
              h_r          <= '0;
              len_r        <= '0;
              state_r      <= S_IDLE;
            end
          end else if (meta_q.len == len_r) begin
            state_r <= S_CMP;
          end else if (n_r == SLOT_LAST) begin
            out_valid_r  <= 1'b1;
            out_status_r <= skht_pkg::ST_FULL;
            out_slot_r   <= '0;
            h_r          <= '0;
            len_r        <= '0;
            state_r      <= S_IDLE;
          end else begin
            slot_r  <= (slot_r == SLOT_LAST) ? '0 : slot_r + SW'(1);
            n_r     <= n_r + SW'(1);
            state_r <= S_META_RD;
          end
        end
        S_CMP: begin
          idx_r <= idx_inc;
          if (kmem_q != buf_byte) begin
            // mismatch: move on or give up
            if (n_r == SLOT_LAST) begin
              out_valid_r  <= 1'b1;
              out_status_r <= skht_pkg::ST_FULL;
              out_slot_r   <= '0;
              h_r          <= '0;
              len_r        <= '0;
              state_r      <= S_IDLE;
            end else begin
              slot_r  <= (slot_r == SLOT_LAST) ? '0 : slot_r + SW'(1);
              n_r     <= n_r + SW'(1);
              state_r <= S_META_RD;
            end
          end else if (idx_inc == len_r) begin
            // stored key matches
            out_valid_r <= 1'b1;
            out_slot_r  <= skht_pkg::SLOT_W'(slot_r);
            h_r         <= '0;
            len_r       <= '0;
            state_r     <= S_IDLE;
            if (mode_r == skht_pkg::MODE_INSERT) begin
              out_status_r <= skht_pkg::ST_INSERTED;
            end else begin
              out_status_r <= meta_q.rem ? skht_pkg::ST_HIT_REMOVED : skht_pkg::ST_HIT;
            end
          end
        end
        S_COPY: begin
          idx_r <= idx_inc;
          if (idx_inc == len_r) begin
            h_r     <= '0;
            len_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/skht_checker.sv]
// ---------------------------------------------------------------------------
// skht_checker
// port-level checks for the string key hash table probe core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module skht_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [skht_pkg::STATUS_W-1:0] out_status,
  input wire logic [skht_pkg::SLOT_W-1:0]   out_slot_index
);

  // reset starts the metadata clearing sweep
  `SKHT_ASSERT_NEXT_ALWAYS(a_reset_busy, !rst_n, busy, "not busy after reset")

  // an accepted byte always occupies the core
  `SKHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "idle right after accept")

  // results are single-cycle strobes, never back to back
  `SKHT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe repeated")

  // failure codes carry slot zero
  `SKHT_ASSERT_NOW(a_fail_slot,
    out_valid && (out_status == skht_pkg::ST_FULL || out_status == skht_pkg::ST_TOO_LONG),
    out_slot_index == '0, "nonzero slot on failure")

  // only defined status codes
  `SKHT_ASSERT_NOW(a_status_code, out_valid, out_status <= skht_pkg::ST_TOO_LONG,
    "undefined status code")

endmodule

bind string_key_hash_table_probe_core skht_checker u_skht_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_slot_index (out_slot_index)
);

`default_nettype wire

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the string key hash table probe core
// ---------------------------------------------------------------------------
// Keys are sent byte by byte through the start/busy handshake. A scoreboard
// keeps its own copy of the slot table, predicts the status and slot of
// every final byte, and checks each strobed result against the oldest
// expectation. Directed keys cover hits, removed marks, restore, misses,
// collisions with wrap at the top slot, zero and 0xff bytes, the longest key
// and keys that are too long. Random keys from a small pool follow under
// several idling phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  logic [skht_pkg::STATUS_W-1:0] status;
  logic [skht_pkg::SLOT_W-1:0]   slot;
} probe_result_t;

class hash_table_scoreboard;
  localparam int NSLOT = skht_pkg::SLOTS_DEF;
  localparam int MAXK  = skht_pkg::MAX_KEY_CHARS_DEF;

  bit             occupied [NSLOT];
  bit             removed  [NSLOT];
  logic [7:0]     slot_bytes [NSLOT][MAXK];
  int             slot_len [NSLOT];
  logic [7:0]     key_in [MAXK];
  int             home_acc;
  int             key_len;
  probe_result_t  expected_q [$];
  int             errors;

  function bit key_equal(int s);
    if (slot_len[s] != key_len) return 0;
    for (int i = 0; i < key_len; i++)
      if (slot_bytes[s][i] != key_in[i]) return 0;
    return 1;
  endfunction

  // one accepted byte transaction
  function void note_byte(logic [1:0] mode, logic [7:0] ch, bit last);
    probe_result_t r;
    int s;
    bit found, empty;
    home_acc = (skht_pkg::HASH_MULT * home_acc + ch) % NSLOT;
    if (key_len < MAXK) key_in[key_len] = ch;
    if (key_len <= MAXK) key_len++;
    if (!last) return;
    found = 0;
    empty = 0;
    s = home_acc;
    if (key_len > MAXK) begin
      r.status = skht_pkg::ST_TOO_LONG;
      r.slot = '0;
    end else begin
      // linear walk with wrap
      for (int n = 0; n < NSLOT; n++) begin
        if (!occupied[s]) begin
          empty = 1;
          break;
        end
        if (key_equal(s)) begin
          found = 1;
          break;
        end
        s = (s + 1) % NSLOT;
      end
      r.slot = skht_pkg::SLOT_W'(s);
      if (!found && !empty) begin
        r.status = skht_pkg::ST_FULL;
        r.slot = '0;
      end else if (mode == skht_pkg::MODE_INSERT) begin
        if (empty) begin
          occupied[s] = 1;
          slot_len[s] = key_len;
          for (int i = 0; i < key_len; i++) slot_bytes[s][i] = key_in[i];
        end
        removed[s] = 0;
        r.status = skht_pkg::ST_INSERTED;
      end else if (found) begin
        r.status = removed[s] ? skht_pkg::ST_HIT_REMOVED : skht_pkg::ST_HIT;
        if (mode == skht_pkg::MODE_REMOVE) removed[s] = 1;
      end else begin
        r.status = skht_pkg::ST_MISS;
      end
    end
    expected_q.push_back(r);
    home_acc = 0;
    key_len = 0;
  endfunction

  // one strobed result
  function void check_result(logic [2:0] status, logic [11:0] slot);
    probe_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result status %0d slot %0d", $time, status, slot);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      errors++;
    end
    if (slot !== e.slot) begin
      $display("%0t: slot_index expected %0d actual %0d", $time, e.slot, slot);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          start = 0;
  logic [skht_pkg::MODE_W-1:0]   in_mode = '0;
  logic [skht_pkg::CHAR_W-1:0]   in_key_char = '0;
  logic                          in_key_last = 0;
  logic                          busy;
  logic                          out_valid;
  logic [skht_pkg::STATUS_W-1:0] out_status;
  logic [skht_pkg::SLOT_W-1:0]   out_slot_index;

  hash_table_scoreboard sb = new();
  int                   idle_pct = 0;
  typedef logic [7:0]   key_t [$];
  key_t                 key_pool [48];

  string_key_hash_table_probe_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_key_char(in_key_char), .in_key_last(in_key_last),
    .out_valid(out_valid), .out_status(out_status), .out_slot_index(out_slot_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("testbench: errors");
    $finish;
  end

  // results sampled away from the driving edge
  always @(negedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_slot_index);
  end

  // one byte transaction, start kept high unless a gap follows
  task automatic send_byte(logic [1:0] mode, logic [7:0] ch, bit last);
    int gap;
    start <= 1;
    in_mode <= mode;
    in_key_char <= ch;
    in_key_last <= last;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_byte(mode, ch, last);
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 0;
      in_mode <= skht_pkg::MODE_W'($urandom);
      in_key_char <= skht_pkg::CHAR_W'($urandom);
      in_key_last <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_key(logic [1:0] mode, key_t k);
    foreach (k[i]) send_byte(mode, k[i], i == k.size() - 1);
  endtask

  task automatic wait_drained();
    start <= 0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // two byte key whose home slot is target, first byte at least a_min
  function automatic key_t key_for_slot(int target, int a_min);
    key_t k;
    int b;
    for (int a = a_min; a < 256; a++) begin
      b = ((target - skht_pkg::HASH_MULT * a) % 4096 + 4096) % 4096;
      if (b < 256) begin
        k = '{a[7:0], b[7:0]};
        return k;
      end
    end
    return k;
  endfunction

  function automatic key_t random_key(int len);
    key_t k;
    for (int i = 0; i < len; i++) k.push_back(8'($urandom));
    return k;
  endfunction

  initial begin
    key_t k, k2;
    int   sent;
    int   len;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: hit, removed, restore, miss, mode three
    k = '{8'h01};
    send_key(skht_pkg::MODE_LOOKUP, k);
    send_key(skht_pkg::MODE_INSERT, k);
    send_key(skht_pkg::MODE_LOOKUP, k);
    send_key(skht_pkg::MODE_REMOVE, k);
    send_key(skht_pkg::MODE_REMOVE, k);
    send_key(skht_pkg::MODE_SPARE, k);
    send_key(skht_pkg::MODE_INSERT, k);
    send_key(skht_pkg::MODE_LOOKUP, k);
    // collision with the same home slot, zero byte
    k = '{8'h00, 8'h01};
    send_key(skht_pkg::MODE_INSERT, k);
    send_key(skht_pkg::MODE_LOOKUP, k);
    send_key(skht_pkg::MODE_REMOVE, '{8'h00, 8'h02});
    // wrap past the top slot
    k = key_for_slot(4095, 1);
    send_key(skht_pkg::MODE_INSERT, k);
    k2 = key_for_slot(4095, int'(k[0]) + 1);
    send_key(skht_pkg::MODE_INSERT, k2);
    send_key(skht_pkg::MODE_LOOKUP, k2);
    // extreme bytes, longest key, too long keys
    send_key(skht_pkg::MODE_INSERT, '{8'hff, 8'h00, 8'hff});
    k = random_key(30);
    send_key(skht_pkg::MODE_INSERT, k);
    send_key(skht_pkg::MODE_LOOKUP, k);
    k.push_back(8'hff);
    send_key(skht_pkg::MODE_LOOKUP, k);
    send_key(skht_pkg::MODE_INSERT, random_key(40));

    // pause until every result is back
    wait_drained();

    foreach (key_pool[i]) begin
      case ($urandom_range(9))
        0:       len = 30;
        1:       len = $urandom_range(31, 34);
        default: len = $urandom_range(1, 6);
      endcase
      key_pool[i] = random_key(len);
    end

    // random phases: no idling, heavy sender idling, light sender idling, none
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 85;
        2:       idle_pct = 29;
        default: idle_pct = 0;
      endcase
      sent = 0;
      while (sent < 325) begin
        if ($urandom_range(9) == 0) k = random_key($urandom_range(1, 8));
        else k = key_pool[$urandom_range(47)];
        send_key(skht_pkg::MODE_W'($urandom_range(3)), k);
        sent += k.size();
      end
    end

    idle_pct = 0;
    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+sv
sv/skht_pkg.sv
sv/string_key_hash_table_probe_core.sv
sv/skht_checker.sv
sim/testbench.sv
